FILE: rtl/uart_tx_ring_burst_drain_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transmit ring burst drain block
// Concurrent checks on clk_i with reset rst_ni; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef UART_TX_RING_BURST_DRAIN_ASSERT_SVH
`define UART_TX_RING_BURST_DRAIN_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define UTRBD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define UTRBD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define UTRBD_ASSERT_NOW(lbl, pre, post, msg)
`define UTRBD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

FILE: rtl/utrbd_pkg.sv
// ----------------------------------------------------------------------------
// utrbd_pkg
// Sizes, types and helpers shared by the transmit ring block and its memory.
// ----------------------------------------------------------------------------
package utrbd_pkg;

  localparam int DEPTH       = 64;  // slots per ring, one is always left open
  localparam int BURST       = 16;  // bytes per drain at most
  localparam int PORTS       = 4;   // serial channels
  localparam int MAX_RESULTS = 16;  // result slots per item

  localparam int BMAX      = (BURST < MAX_RESULTS) ? BURST : MAX_RESULTS;
  localparam int SW        = $clog2(DEPTH);
  localparam int PW        = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int MEM_WORDS = PORTS * (1 << SW);
  localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CW        = $clog2(BMAX + 1);
  localparam int OW        = ((SW + 1) > CW) ? (SW + 1) : CW;

  // item modes
  localparam logic MODE_HOST_WRITE = 1'b0;  // host writes a byte
  localparam logic MODE_TX_READY   = 1'b1;  // UART can take a burst

  typedef logic [SW-1:0] slot_t;
  typedef logic [PW-1:0] pidx_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [OW-1:0] occ_t;

  // One cycle of ring memory traffic.
  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    logic       re;
    addr_t      raddr;
  } mem_req_t;

  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    if (s == SW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  function automatic addr_t ring_addr(input pidx_t p, input slot_t s);
    return AW'({p, s});
  endfunction

endpackage

FILE: rtl/utrbd_ring_mem.sv
// ----------------------------------------------------------------------------
// utrbd_ring_mem
// Byte store for all transmit rings; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module utrbd_ring_mem
  import utrbd_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [MEM_WORDS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/uart_tx_ring_burst_drain.sv
// ----------------------------------------------------------------------------
// uart_tx_ring_burst_drain
// Per-port transmit rings in one shared memory, drained to the UART in bursts.
// ----------------------------------------------------------------------------
// Path: a drained byte passes the read issue, the registered memory read and the
//   output register; a single result is loaded straight into the output register.
// Throughput: the input is held until an item's last result is loaded; drained
//   bytes leave one per cycle unless out_ready_i stalls, paced by the ring memory read port.
// Reset: indexes and busy flags clear at once; ring bytes are not cleared, no
//   clearing pass is needed since only written slots are ever read.
// ----------------------------------------------------------------------------
`include "uart_tx_ring_burst_drain_assert.svh"

module uart_tx_ring_burst_drain
  import utrbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  logic [1:0] port_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_block_i,   // block framing only, no effect on the rings

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepted_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic       busy_res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,    // item with no drained byte: one result
    S_DRAIN   // reading the burst out of the ring memory
  } state_e;

  state_e state_q;

  // per-port ring pointers: write points at newest byte, read at last sent
  slot_t            wi_q [PORTS];
  slot_t            ri_q [PORTS];
  logic [PORTS-1:0] busy_q;

  // the item at work
  pidx_t cur_p_q;
  logic  acc_q;
  logic  cur_busy_q;
  cnt_t  rd_left_q;    // reads still to issue
  cnt_t  out_left_q;   // results still to load
  logic  rdv_q;        // memory read data waiting for the output register

  // output register
  logic       out_valid_q;
  logic       accepted_q;
  logic       tx_valid_q;
  logic [7:0] tx_byte_q;
  logic       last_q;
  logic       busy_res_q;

  mem_req_t   mreq;
  logic [7:0] rdata;

  // --------------------------------------------------------------------------
  // Item decode, done in the accept cycle
  // --------------------------------------------------------------------------
  logic  take;
  logic  p_ok;
  pidx_t pidx;
  slot_t wi_c, ri_c, wi_inc, wi_new;
  logic  full;
  logic  do_write;
  occ_t  occ;
  logic  drain;
  cnt_t  n_new;
  logic  busy_new;
  logic  acc_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    p_ok     = (32'(port_i) < PORTS);
    pidx     = PW'(port_i);
    wi_c     = p_ok ? wi_q[pidx] : '0;
    ri_c     = p_ok ? ri_q[pidx] : '0;
    wi_inc   = slot_inc(wi_c);
    full     = (wi_inc == ri_c);
    acc_new  = p_ok && (mode_i == MODE_HOST_WRITE) && !full;
    do_write = take && acc_new;
    wi_new   = acc_new ? wi_inc : wi_c;
    // bytes in the ring after the enqueue
    if (wi_new >= ri_c) begin
      occ = OW'(wi_new) - OW'(ri_c);
    end else begin
      occ = OW'(wi_new) + OW'(DEPTH) - OW'(ri_c);
    end
    if (!p_ok) begin
      drain    = 1'b0;
      busy_new = 1'b0;
    end else if (mode_i == MODE_TX_READY) begin
      drain    = (occ != '0);
      busy_new = drain;
    end else begin
      drain    = !busy_q[pidx];
      busy_new = 1'b1;
    end
    if (!drain) begin
      n_new = '0;
    end else if (occ > OW'(BMAX)) begin
      n_new = CW'(BMAX);
    end else begin
      n_new = CW'(occ);
    end
  end

  // --------------------------------------------------------------------------
  // Drain pipeline: read issue -> read data -> output register
  // --------------------------------------------------------------------------
  logic  out_free;
  logic  ld_one;
  logic  ld_byte;
  logic  issue;
  slot_t rd_slot;

  assign out_free = !out_valid_q || out_ready_i;
  assign ld_one   = (state_q == S_ONE) && out_free;
  assign ld_byte  = (state_q == S_DRAIN) && rdv_q && out_free;
  assign issue    = (state_q == S_DRAIN) && (rd_left_q != '0) && (!rdv_q || ld_byte);
  assign rd_slot  = slot_inc(ri_q[cur_p_q]);

  always_comb begin
    mreq.we    = do_write;
    mreq.waddr = ring_addr(pidx, wi_inc);
    mreq.wdata = data_byte_i;
    mreq.re    = issue;
    mreq.raddr = ring_addr(cur_p_q, rd_slot);
  end

  utrbd_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer, pointers and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      for (int i = 0; i < PORTS; i++) begin
        wi_q[i] <= '0;
        ri_q[i] <= '0;
      end
      cur_p_q     <= '0;
      acc_q       <= 1'b0;
      cur_busy_q  <= 1'b0;
      rd_left_q   <= '0;
      out_left_q  <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      tx_valid_q  <= 1'b0;
      tx_byte_q   <= '0;
      last_q      <= 1'b0;
      busy_res_q  <= 1'b0;
    end else begin
      // a load refills the output register in the cycle it empties
      if (ld_one || ld_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            cur_p_q    <= pidx;
            acc_q      <= acc_new;
            cur_busy_q <= busy_new;
            rd_left_q  <= n_new;
            out_left_q <= n_new;
            if (p_ok) begin
              wi_q[pidx]   <= wi_new;
              busy_q[pidx] <= busy_new;
            end
            state_q <= (n_new == '0) ? S_ONE : S_DRAIN;
          end
        end

        S_ONE: begin
          if (ld_one) begin
            accepted_q  <= acc_q;
            tx_valid_q  <= 1'b0;
            tx_byte_q   <= '0;
            last_q      <= 1'b1;
            busy_res_q  <= cur_busy_q;
            state_q     <= S_IDLE;
          end
        end

        S_DRAIN: begin
          if (issue) begin
            ri_q[cur_p_q] <= rd_slot;
            rd_left_q     <= rd_left_q - cnt_t'(1);
          end
          if (issue) begin
            rdv_q <= 1'b1;
          end else if (ld_byte) begin
            rdv_q <= 1'b0;
          end
          if (ld_byte) begin
            accepted_q  <= acc_q;
            tx_valid_q  <= 1'b1;
            tx_byte_q   <= rdata;
            last_q      <= (out_left_q == cnt_t'(1));
            busy_res_q  <= cur_busy_q;
            out_left_q  <= out_left_q - cnt_t'(1);
            if (out_left_q == cnt_t'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_o      = last_q;
  assign busy_res_o  = busy_res_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `UTRBD_ASSERT_NOW(a_idle_no_data, state_q == S_IDLE, !rdv_q, "read data stranded in idle")
  `UTRBD_ASSERT_NOW(a_issue_budget, issue, out_left_q >= rd_left_q && rd_left_q != '0, "read overrun")
  `UTRBD_ASSERT_NEXT(a_data_kept, rdv_q && !ld_byte, rdv_q && $stable(rdata), "read data lost")
  `UTRBD_ASSERT_NOW(a_last_ends, ld_byte && out_left_q == cnt_t'(1), rd_left_q == '0, "early last")

endmodule
